/* rtl/blc_pkg.sv */
// Shared types and constants for the breakpoint color lookup.
package blc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int COL_W         = 32;
    localparam int DIFF_W        = KEY_BITS + 1;
    localparam int NUM_W         = KEY_BITS + 9;
    localparam int DD_W          = DIFF_W + 7;
    localparam int QUO_W         = 8;

    localparam logic [1:0] CFG_ENTRY_COUNT   = 2'd0;
    localparam logic [1:0] CFG_CLAMP_OUTSIDE = 2'd1;
    localparam logic [1:0] CFG_INTERP_MODE   = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // table write broadcast to all cells
    typedef struct packed {
        logic                       en;
        logic [IDX_W-1:0]           idx;
        logic signed [KEY_BITS-1:0] key;
        logic [COL_W-1:0]           col;
    } t_wr;

    // scan token passed from cell to cell
    typedef struct packed {
        logic                       active;
        logic signed [KEY_BITS-1:0] s;
        logic                       hp;
        logic                       hn;
        logic signed [KEY_BITS-1:0] kp;
        logic [COL_W-1:0]           cp;
        logic signed [KEY_BITS-1:0] kn;
        logic [COL_W-1:0]           cn;
    } t_scan;

endpackage

/* rtl/blc_cell.sv */
// One breakpoint cell: holds an entry and updates the passing scan token.
module blc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  blc_pkg::t_wr              i_wr,
    input  logic [blc_pkg::IDX_W-1:0] i_idx,
    input  logic [blc_pkg::CNT_W-1:0] i_count,
    input  blc_pkg::t_scan            i_scan,
    output blc_pkg::t_scan            o_scan
);
    import blc_pkg::*;

    logic signed [KEY_BITS-1:0] r_key;
    logic [COL_W-1:0]           r_col;
    t_scan                      r_scan;
    t_scan                      n_scan;

    // store the entry addressed to this cell
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.idx == i_idx) begin
            r_key <= i_wr.key;
            r_col <= i_wr.col;
        end
    end

    // update the token while no larger key has been found
    always_comb begin
        n_scan = i_scan;
        if (i_scan.active && !i_scan.hn && ({1'b0, i_idx} < i_count)) begin
            if (i_scan.s < r_key) begin
                n_scan.hn = 1'b1;
                n_scan.kn = r_key;
                n_scan.cn = r_col;
            end else begin
                n_scan.hp = 1'b1;
                n_scan.kp = r_key;
                n_scan.cp = r_col;
            end
        end
    end

    // advance the token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.active <= 1'b0;
        end else begin
            r_scan <= n_scan;
        end
    end

    assign o_scan = r_scan;

endmodule

/* rtl/blc_div.sv */
// Restoring divider lane: one quotient bit per step.
module blc_div (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_step,
    input  logic [blc_pkg::NUM_W-1:0]  i_num,
    input  logic [blc_pkg::DIFF_W-1:0] i_den,
    output logic [blc_pkg::QUO_W-1:0]  o_quo
);
    import blc_pkg::*;

    logic [NUM_W-1:0] r_rem;
    logic [DD_W-1:0]  r_dd;
    logic [QUO_W-1:0] r_quo;
    logic             w_ge;

    assign w_ge = r_rem >= NUM_W'(r_dd);

    // load operands, then subtract the shifted divisor bit by bit
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_num;
            r_dd  <= {i_den, 7'd0};
            r_quo <= '0;
        end else if (i_step) begin
            if (w_ge) begin
                r_rem <= r_rem - NUM_W'(r_dd);
            end
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
            r_dd  <= r_dd >> 1;
        end
    end

    assign o_quo = r_quo;

endmodule

/* rtl/breakpoint_color_lookup.sv */
// Breakpoint color lookup: scan one lookup beat through the cell chain.
// Edge and nearest results come straight from the scan; a blend also passes through the
// multiplier load state (S_MUL), the 8-step divider (S_DIV) and S_DONE before output.
// One item in flight: a new beat is accepted only in idle, after the result has been taken;
// a write does not leave idle, so it does not hold off the next beat.
// Reset (synchronous, active low): entry_count 1, clamping on, blend mode; table undefined.
module breakpoint_color_lookup (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [4:0]                   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_command,
    input  logic [3:0]                   i_entry_index,
    input  logic signed [15:0]           i_entry_key,
    input  logic [7:0]                   i_entry_red,
    input  logic [7:0]                   i_entry_green,
    input  logic [7:0]                   i_entry_blue,
    input  logic [7:0]                   i_entry_alpha,
    input  logic signed [15:0]           i_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [7:0]                   o_out_red,
    output logic [7:0]                   o_out_green,
    output logic [7:0]                   o_out_blue,
    output logic [7:0]                   o_out_alpha,
    output logic                         o_out_of_range
);
    import blc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state;
    logic [4:0]        r_count;
    logic              r_clamp;
    logic              r_interp;
    logic [2:0]        r_step;
    logic [COL_W-1:0]  r_col;
    logic              r_oor;
    logic [COL_W-1:0]  r_cp;
    logic [COL_W-1:0]  r_cn;
    logic [DIFF_W-1:0] r_dp;
    logic [DIFF_W-1:0] r_dn;
    logic [DIFF_W-1:0] r_d;

    logic              w_acc;
    logic [CNT_W-1:0]  w_n;
    t_wr               w_wr;
    t_scan             w_chain [TABLE_ENTRIES+1];
    t_scan             w_f;
    logic [DIFF_W-1:0] w_dp;
    logic [DIFF_W-1:0] w_dn;
    logic [QUO_W-1:0]  w_quo [4];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_acc       = i_in_valid && o_in_ready;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 5'd1;
            r_clamp  <= 1'b1;
            r_interp <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT:   r_count  <= i_cfg_data;
                CFG_CLAMP_OUTSIDE: r_clamp  <= i_cfg_data[0];
                CFG_INTERP_MODE:   r_interp <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // saturate the count into one to the table size
    always_comb begin
        if (r_count == 5'd0) begin
            w_n = CNT_W'(1);
        end else if (CNT_W'(r_count) > CNT_W'(TABLE_ENTRIES) || r_count[4:CNT_W-1] != '0
                     && CNT_W < 5) begin
            w_n = CNT_W'(TABLE_ENTRIES);
        end else begin
            w_n = CNT_W'(r_count);
        end
    end

    // broadcast writes and inject lookups at the head of the chain
    always_comb begin
        w_wr.en  = w_acc && (i_command == CMD_WRITE);
        w_wr.idx = IDX_W'(i_entry_index);
        w_wr.key = i_entry_key;
        w_wr.col = {i_entry_red, i_entry_green, i_entry_blue, i_entry_alpha};
        w_chain[0]        = '0;
        w_chain[0].active = w_acc && (i_command == CMD_LOOKUP);
        w_chain[0].s      = i_sample;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        blc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_idx   (IDX_W'(g)),
            .i_count (w_n),
            .i_scan  (w_chain[g]),
            .o_scan  (w_chain[g+1])
        );
    end

    assign w_f  = w_chain[TABLE_ENTRIES];
    assign w_dp = DIFF_W'(w_f.s) - DIFF_W'(w_f.kp);
    assign w_dn = DIFF_W'(w_f.kn) - DIFF_W'(w_f.s);

    for (genvar c = 0; c < 4; c++) begin : g_lane
        logic [NUM_W-1:0] w_num;
        assign w_num = NUM_W'(r_cp[8*c +: 8]) * NUM_W'(r_dn)
                     + NUM_W'(r_cn[8*c +: 8]) * NUM_W'(r_dp)
                     + NUM_W'(r_d >> 1);
        blc_div u_div (
            .i_clk  (i_clk),
            .i_load (r_state == S_MUL),
            .i_step (r_state == S_DIV),
            .i_num  (w_num),
            .i_den  (r_d),
            .o_quo  (w_quo[c])
        );
    end

    // sequence scan, blend and output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_acc && i_command == CMD_LOOKUP) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_f.active) begin
                        r_cp <= w_f.cp;
                        r_cn <= w_f.cn;
                        r_dp <= w_dp;
                        r_dn <= w_dn;
                        r_d  <= DIFF_W'(w_f.kn) - DIFF_W'(w_f.kp);
                        if (!w_f.hp) begin
                            r_oor   <= 1'b1;
                            r_col   <= r_clamp ? '0 : w_f.cn;
                            r_state <= S_OUT;
                        end else if (!w_f.hn) begin
                            r_oor   <= (w_f.s != w_f.kp);
                            r_col   <= (r_clamp && w_f.s != w_f.kp) ? '0 : w_f.cp;
                            r_state <= S_OUT;
                        end else if (!r_interp) begin
                            r_oor   <= 1'b0;
                            r_col   <= (w_dp < w_dn) ? w_f.cp : w_f.cn;
                            r_state <= S_OUT;
                        end else begin
                            r_oor   <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_col   <= {w_quo[3], w_quo[2], w_quo[1], w_quo[0]};
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = (r_state == S_OUT);
    assign o_out_red      = r_col[31:24];
    assign o_out_green    = r_col[23:16];
    assign o_out_blue     = r_col[15:8];
    assign o_out_alpha    = r_col[7:0];
    assign o_out_of_range = r_oor;

endmodule
